@@ src/fibonacci_delta_sample_encoder_unit_defines.svh @@
// assertion macros used by the checker file of the delta sample encoder
`ifndef FIBONACCI_DELTA_SAMPLE_ENCODER_UNIT_DEFINES_SVH
`define FIBONACCI_DELTA_SAMPLE_ENCODER_UNIT_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FDSE_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdse assertion failed");

// next-cycle implication, disabled while in reset
`define FDSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdse assertion failed");

`endif

@@ src/fdse_pkg.sv @@
// types and constants of the fibonacci delta sample encoder
`default_nettype none

package fdse_pkg;

    localparam int unsigned TOTAL_W = 24;
    localparam int unsigned SUM_W   = 10;

    // delta for each 4-bit code
    localparam logic signed [6:0] DELTA_TAB [16] = '{
        -7'sd34, -7'sd21, -7'sd13, -7'sd8, -7'sd5, -7'sd3, -7'sd2, -7'sd1,
         7'sd0,   7'sd1,   7'sd2,   7'sd3,  7'sd5,  7'sd8,  7'sd13, 7'sd21
    };

    localparam logic signed [SUM_W-1:0] RECON_MIN = -10'sd128;
    localparam logic [3:0]              CODE_MAX  = 4'd15;
    localparam logic [7:0]              PAD_BYTE  = 8'h00;

    typedef struct packed {
        logic [7:0]         out_byte;
        logic               has_byte;
        logic               end_of_stream;
        logic [TOTAL_W-1:0] mismatch_total;
        logic [TOTAL_W-1:0] sample_total;
    } word_t;

    // up to three result words caused by one sample, w0 goes out first
    typedef struct packed {
        logic [1:0] cnt;
        word_t      w0;
        word_t      w1;
        word_t      w2;
    } bundle_t;

endpackage

`default_nettype wire

@@ src/fdse_core.sv @@
// input register, encoder state and per-sample result bundle
`default_nettype none

module fdse_core #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,
    input  wire logic              s_tlast,
    input  wire logic              load_ok,
    output logic                   bundle_push,
    output fdse_pkg::bundle_t      bundle
);

    logic                          in_valid_reg;
    logic signed [7:0]             in_sample_reg;
    logic                          in_last_reg;

    logic signed [7:0]             recon_reg, recon_next;
    logic                          first_seen_reg, first_seen_next;
    logic                          pair_phase_reg, pair_phase_next;
    logic [3:0]                    held_code_reg, held_code_next;
    logic [COUNT_BITS-1:0]         mis_reg, mis_next;
    logic [COUNT_BITS-1:0]         smp_reg, smp_next;

    logic                          process;
    logic                          first;
    logic                          enc;
    logic signed [7:0]             prev;
    logic signed [fdse_pkg::SUM_W-1:0] prev_ext;
    logic signed [fdse_pkg::SUM_W-1:0] samp_ext;
    logic signed [fdse_pkg::SUM_W-1:0] sum_arr [16];
    logic [15:1]                   le;
    logic [3:0]                    code_base;
    logic [3:0]                    code;
    logic signed [7:0]             recon_calc;
    logic [COUNT_BITS-1:0]         mis_upd;
    logic [COUNT_BITS-1:0]         smp_upd;
    logic [COUNT_BITS-1:0]         one_c;
    fdse_pkg::word_t               w_pad, w_raw, w_pair, w_stat;

    assign one_c    = {{(COUNT_BITS-1){1'b0}}, 1'b1};
    assign first    = !first_seen_reg;
    assign enc      = pair_phase_reg || !in_last_reg;
    assign prev     = first ? in_sample_reg : recon_reg;
    assign prev_ext = fdse_pkg::SUM_W'(prev);
    assign samp_ext = fdse_pkg::SUM_W'(in_sample_reg);

    // largest delta that keeps the reconstruction at or below the sample
    always_comb
    begin
        for (int t = 0; t < 16; t++)
        begin
            sum_arr[t] = prev_ext + fdse_pkg::SUM_W'(fdse_pkg::DELTA_TAB[t]);
        end
        for (int t = 1; t < 16; t++)
        begin
            le[t] = (sum_arr[t] <= samp_ext);
        end
    end

    assign code_base = 4'($countones(le));
    assign code      = ((sum_arr[code_base] < fdse_pkg::RECON_MIN)
                        && (code_base != fdse_pkg::CODE_MAX))
                       ? code_base + 4'd1 : code_base;
    assign recon_calc = 8'(sum_arr[code]);

    always_comb
    begin
        mis_upd = mis_reg;
        smp_upd = smp_reg;
        if (enc)
        begin
            if (recon_calc != in_sample_reg)
            begin
                mis_upd = (mis_reg == '1) ? mis_reg : mis_reg + one_c;
            end
            smp_upd = (smp_reg == '1) ? smp_reg : smp_reg + one_c;
        end
    end

    // candidate result words
    always_comb
    begin
        w_pad                = '0;
        w_pad.out_byte       = fdse_pkg::PAD_BYTE;
        w_pad.has_byte       = 1'b1;
        w_raw                = '0;
        w_raw.out_byte       = in_sample_reg;
        w_raw.has_byte       = 1'b1;
        w_pair               = '0;
        w_pair.out_byte      = {held_code_reg, code};
        w_pair.has_byte      = 1'b1;
        w_stat               = '0;
        w_stat.end_of_stream = 1'b1;
        w_stat.mismatch_total = fdse_pkg::TOTAL_W'(mis_upd);
        w_stat.sample_total   = fdse_pkg::TOTAL_W'(smp_upd);
    end

    // order: pad, raw value, code pair, status
    always_comb
    begin
        bundle = '0;
        if (first)
        begin
            bundle.cnt = 2'd2 + {1'b0, in_last_reg};
            bundle.w0  = w_pad;
            bundle.w1  = w_raw;
            bundle.w2  = w_stat;
        end
        else if (pair_phase_reg)
        begin
            bundle.cnt = 2'd1 + {1'b0, in_last_reg};
            bundle.w0  = w_pair;
            bundle.w1  = w_stat;
        end
        else
        begin
            bundle.cnt = {1'b0, in_last_reg};
            bundle.w0  = w_stat;
        end
    end

    assign process     = in_valid_reg && ((bundle.cnt == 2'd0) || load_ok);
    assign bundle_push = process && (bundle.cnt != 2'd0);
    assign s_tready    = !in_valid_reg || process;

    always_comb
    begin
        recon_next      = recon_reg;
        first_seen_next = first_seen_reg;
        pair_phase_next = pair_phase_reg;
        held_code_next  = held_code_reg;
        mis_next        = mis_reg;
        smp_next        = smp_reg;
        if (process)
        begin
            if (in_last_reg)
            begin
                // stream done, back to reset state
                recon_next      = '0;
                first_seen_next = 1'b0;
                pair_phase_next = 1'b0;
                held_code_next  = '0;
                mis_next        = '0;
                smp_next        = '0;
            end
            else
            begin
                recon_next      = recon_calc;
                first_seen_next = 1'b1;
                pair_phase_next = !pair_phase_reg;
                if (!pair_phase_reg)
                begin
                    held_code_next = code;
                end
                mis_next        = mis_upd;
                smp_next        = smp_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            recon_reg      <= '0;
            first_seen_reg <= 1'b0;
            pair_phase_reg <= 1'b0;
            held_code_reg  <= '0;
            mis_reg        <= '0;
            smp_reg        <= '0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            recon_reg      <= recon_next;
            first_seen_reg <= first_seen_next;
            pair_phase_reg <= pair_phase_next;
            held_code_reg  <= held_code_next;
            mis_reg        <= mis_next;
            smp_reg        <= smp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_sample_reg <= s_tdata;
            in_last_reg   <= s_tlast;
        end
    end

endmodule

`default_nettype wire

@@ src/fdse_emit.sv @@
// result register queue that sends one word per cycle while m_tready is high
`default_nettype none

module fdse_emit (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              bundle_push,
    input  wire fdse_pkg::bundle_t bundle,
    output logic                   load_ok,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output fdse_pkg::word_t        word
);

    fdse_pkg::word_t words_reg [3];
    logic [1:0]      cnt_reg, cnt_next;
    logic            pop;

    assign m_tvalid = (cnt_reg != 2'd0);
    assign pop      = m_tvalid && m_tready;
    // a new bundle fits once the last held word leaves
    assign load_ok  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && m_tready);
    assign word     = words_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (bundle_push)
        begin
            cnt_next = bundle.cnt;
        end
        else if (pop)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bundle_push)
        begin
            words_reg[0] <= bundle.w0;
            words_reg[1] <= bundle.w1;
            words_reg[2] <= bundle.w2;
        end
        else if (pop)
        begin
            words_reg[0] <= words_reg[1];
            words_reg[1] <= words_reg[2];
        end
    end

endmodule

`default_nettype wire

@@ src/fibonacci_delta_sample_encoder_unit.sv @@
// top level of the fibonacci delta sample encoder
//
//  port group   dir  tdata                                 tuser     tlast
//  s_*          in   [7:0] sample                          -         last_sample
//  m_*          out  [7:0] out_byte, [31:8] mismatch_total, has_byte  end_of_stream
//                    [55:32] sample_total
//
// one sample sits in an input register, is encoded combinationally, and its result
// words (zero to three) load a three-word result queue; the first word shows once
// the sample's bundle has been loaded into the result queue registers
// the output sends one word per cycle while m_tready is high, so a sample is taken
// every cycle while each makes at most one word; the first sample of a stream makes
// two words (three if also final) and a final sample closing a pair makes two
// rst_n clears all stream state, the input register and the result queue; m_tready
// low holds the queue and stalls the input register only once a new bundle cannot
// be loaded
`default_nettype none

module fibonacci_delta_sample_encoder_unit #(
    parameter int unsigned COUNT_BITS = 24
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // out_byte, mismatch_total, sample_total
    output logic             m_tuser,   // has_byte
    output logic             m_tlast
);

    fdse_pkg::bundle_t bundle;
    logic              bundle_push;
    logic              load_ok;
    fdse_pkg::word_t   word;

    fdse_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .load_ok     (load_ok),
        .bundle_push (bundle_push),
        .bundle      (bundle)
    );

    fdse_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .bundle_push (bundle_push),
        .bundle      (bundle),
        .load_ok     (load_ok),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .word        (word)
    );

    assign m_tdata = {word.sample_total, word.mismatch_total, word.out_byte};
    assign m_tuser = word.has_byte;
    assign m_tlast = word.end_of_stream;

endmodule

`default_nettype wire

@@ src/fdse_checker.sv @@
// port-level checks of the delta sample encoder, bound to the top level
`default_nettype none
`include "fibonacci_delta_sample_encoder_unit_defines.svh"

module fdse_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [7:0]  s_tdata,
    input wire logic        s_tlast,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [55:0] m_tdata,
    input wire logic        m_tuser,
    input wire logic        m_tlast
);

    logic        out_stall;
    logic        in_stall;
    logic [57:0] out_bus;
    logic [8:0]  in_bus;

    assign out_stall = m_tvalid && !m_tready;
    assign in_stall  = s_tvalid && !s_tready;
    assign out_bus   = {m_tlast, m_tuser, m_tdata};
    assign in_bus    = {s_tlast, s_tdata};

    // a stalled output word stays put
    `FDSE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_tvalid && $stable(out_bus))
    // a waiting input word stays put
    `FDSE_ASSERT_NEXT(a_in_hold, clk, rst_n, in_stall, s_tvalid && $stable(in_bus))
    // byte words and the status word are told apart by the flag
    `FDSE_ASSERT_NOW(a_flag_vs_last, clk, rst_n, m_tvalid, m_tuser != m_tlast)
    // totals only travel on the status word
    `FDSE_ASSERT_NOW(a_totals_zero, clk, rst_n, m_tvalid && !m_tlast, m_tdata[55:8] == 48'd0)
    // the status word carries no byte
    `FDSE_ASSERT_NOW(a_status_byte, clk, rst_n, m_tvalid && m_tlast, m_tdata[7:0] == 8'd0)

endmodule

bind fibonacci_delta_sample_encoder_unit fdse_checker u_fdse_checker (.*);

`default_nettype wire
